[sv/bcomp_pkg.sv]
// shared types, constants and helpers of the barometer compensation pipeline
// no dependencies
package bcomp_pkg;

  localparam int unsigned RAW_BITS = 20;
  localparam int unsigned RAW_WIDTH_DEF = 20;
  localparam int unsigned DIV_STAGES = 64;

  typedef enum logic [2:0] {
    CAL_T1_T2 = 3'd0,
    CAL_T3_P1 = 3'd1,
    CAL_P2_P3 = 3'd2,
    CAL_P4_P5 = 3'd3,
    CAL_P6_P7 = 3'd4,
    CAL_P8_P9 = 3'd5
  } cal_idx_e;

  typedef struct packed {
    logic [RAW_BITS-1:0] raw_temperature;
    logic [RAW_BITS-1:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] temperature_centi;
    logic [31:0]        pressure_q8;
    logic               pressure_invalid;
  } out_word_t;

  typedef struct packed {
    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0]        p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic signed [23:0] temp;
    logic               inv;
  } tag_t;

  // low 64 bits of a 64-bit by 16-bit product from its two partial products
  function automatic logic [63:0] join_pp(logic signed [49:0] lo, logic [31:0] hi);
    logic [63:0] lo_ext;
    lo_ext = 64'(lo);
    return lo_ext + {hi, 32'b0};
  endfunction

endpackage

[sv/bcomp_temp.sv]
// temperature stages: fine temperature, centi-degree result, pressure offset term
// depends on bcomp_pkg
module bcomp_temp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [bcomp_pkg::RAW_BITS-1:0] adc_t_i,
  input  logic [bcomp_pkg::RAW_BITS-1:0] adc_p_i,
  input  bcomp_pkg::cal_t               cal_i,
  output logic                          valid_o,
  output logic signed [25:0]            a_o,
  output logic signed [23:0]            temp_o,
  output logic [bcomp_pkg::RAW_BITS-1:0] adc_p_o
);
  import bcomp_pkg::*;

  logic [4:0] vld_q;
  logic signed [18:0] x1_q;
  logic signed [17:0] d_q;
  logic signed [34:0] m1_q;
  logic signed [35:0] dd_q;
  logic signed [23:0] v1_q;
  logic signed [39:0] m2_q;
  logic signed [24:0] fine_q;
  logic signed [25:0] a_q;
  logic signed [23:0] temp_q;
  logic [RAW_BITS-1:0] ap1_q, ap2_q, ap3_q, ap4_q, ap5_q;
  logic signed [27:0] f28, t28;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_comb begin
    f28 = 28'(fine_q);
    t28 = (f28 <<< 2) + f28 + 28'sd128;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x1_q   <= $signed({2'b0, adc_t_i[19:3]}) - $signed({2'b0, cal_i.t1, 1'b0});
      d_q    <= $signed({2'b0, adc_t_i[19:4]}) - $signed({2'b0, cal_i.t1});
      ap1_q  <= adc_p_i;
      m1_q   <= x1_q * cal_i.t2;
      dd_q   <= d_q * d_q;
      ap2_q  <= ap1_q;
      v1_q   <= 24'(m1_q >>> 11);
      m2_q   <= $signed(dd_q[35:12]) * cal_i.t3;
      ap3_q  <= ap2_q;
      fine_q <= 25'(v1_q) + 25'(m2_q >>> 14);
      ap4_q  <= ap3_q;
      // result always fits the 24-bit field
      temp_q <= 24'(t28 >>> 8);
      a_q    <= 26'(fine_q) - 26'sd128000;
      ap5_q  <= ap4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign a_o     = a_q;
  assign temp_o  = temp_q;
  assign adc_p_o = ap5_q;
endmodule

[sv/bcomp_pfront.sv]
// pressure front stages: offset, divisor and dividend magnitudes
// depends on bcomp_pkg
module bcomp_pfront (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [25:0]            a_i,
  input  logic signed [23:0]            temp_i,
  input  logic [bcomp_pkg::RAW_BITS-1:0] adc_p_i,
  input  bcomp_pkg::cal_t               cal_i,
  output logic                          valid_o,
  output logic [63:0]                   nmag_o,
  output logic [30:0]                   dmag_o,
  output logic                          neg_o,
  output bcomp_pkg::tag_t               tag_o
);
  import bcomp_pkg::*;

  logic [6:0] vld_q;
  logic signed [23:0] tmp_q [6];
  logic [RAW_BITS-1:0] adc_q [3];
  logic signed [51:0] aa_q;
  logic signed [41:0] ap5_q, ap5b_q, ap2_q, ap2b_q, ap2c_q;
  logic signed [49:0] lo6_q, lo3_q, lo1_q, lon_q;
  logic [31:0] hi6_q, hi3_q, hi1_q, hin_q;
  logic [63:0] b_q, c_q, s47_q, nb_q, num_q;
  logic signed [30:0] dv_q;
  logic [63:0] nmag_q;
  logic [30:0] dmag_q;
  logic neg_q;
  tag_t tag_q;

  logic [63:0] aa64;
  logic signed [49:0] h6, h3, h1, hn;
  logic [63:0] prod1;
  logic [20:0] pdiff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_comb begin
    aa64  = 64'(aa_q);
    h6    = $signed({1'b0, aa64[63:32]}) * cal_i.p6;
    h3    = $signed({1'b0, aa64[63:32]}) * cal_i.p3;
    h1    = $signed({1'b0, s47_q[63:32]}) * $signed({1'b0, cal_i.p1});
    hn    = $signed({1'b0, nb_q[63:32]}) * $signed(17'd3125);
    prod1 = join_pp(lo1_q, hi1_q);
    pdiff = 21'h100000 - {1'b0, adc_q[2]};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tmp_q[0] <= temp_i;
      for (int i = 1; i < 6; i++) begin
        tmp_q[i] <= tmp_q[i-1];
      end
      adc_q[0] <= adc_p_i;
      adc_q[1] <= adc_q[0];
      adc_q[2] <= adc_q[1];
      // a squared and the linear terms
      aa_q   <= a_i * a_i;
      ap5_q  <= a_i * cal_i.p5;
      ap2_q  <= a_i * cal_i.p2;
      // partial products of the wrapped 64-bit multiplies
      lo6_q  <= $signed({1'b0, aa64[31:0]}) * cal_i.p6;
      hi6_q  <= h6[31:0];
      lo3_q  <= $signed({1'b0, aa64[31:0]}) * cal_i.p3;
      hi3_q  <= h3[31:0];
      ap5b_q <= ap5_q;
      ap2b_q <= ap2_q;
      b_q    <= join_pp(lo6_q, hi6_q) + (64'(ap5b_q) << 17) + (64'(cal_i.p4) << 35);
      c_q    <= join_pp(lo3_q, hi3_q);
      ap2c_q <= ap2b_q;
      s47_q  <= 64'($signed(c_q) >>> 8) + (64'(ap2c_q) << 12) + 64'h0000_8000_0000_0000;
      nb_q   <= (64'(pdiff) << 31) - b_q;
      lo1_q  <= $signed({1'b0, s47_q[31:0]}) * $signed({1'b0, cal_i.p1});
      hi1_q  <= h1[31:0];
      lon_q  <= $signed({1'b0, nb_q[31:0]}) * $signed(17'd3125);
      hin_q  <= hn[31:0];
      dv_q   <= $signed(prod1[63:33]);
      num_q  <= join_pp(lon_q, hin_q);
      nmag_q <= num_q[63] ? 64'(-num_q) : num_q;
      dmag_q <= dv_q[30] ? 31'(-dv_q) : dv_q;
      neg_q  <= num_q[63] ^ dv_q[30];
      tag_q.temp <= tmp_q[5];
      tag_q.inv  <= (dv_q == 31'sd0);
    end
  end

  assign valid_o = vld_q[6];
  assign nmag_o  = nmag_q;
  assign dmag_o  = dmag_q;
  assign neg_o   = neg_q;
  assign tag_o   = tag_q;
endmodule

[sv/bcomp_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on bcomp_pkg
module bcomp_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  logic [63:0]     nmag_i,
  input  logic [30:0]     dmag_i,
  input  logic            neg_i,
  input  bcomp_pkg::tag_t tag_i,
  output logic            valid_o,
  output logic [63:0]     quot_o,
  output logic            neg_o,
  output bcomp_pkg::tag_t tag_o
);
  import bcomp_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [30:0] rem_q [DIV_STAGES];
  logic [63:0] nq_q  [DIV_STAGES];
  logic [30:0] dm_q  [DIV_STAGES];
  logic        neg_q [DIV_STAGES];
  tag_t        tag_q [DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[DIV_STAGES-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [30:0] rem_in, dm_in;
    logic [63:0] nq_in;
    logic        neg_in;
    tag_t        tag_in;
    logic [31:0] trial;
    logic        ge;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = nmag_i;
      assign dm_in  = dmag_i;
      assign neg_in = neg_i;
      assign tag_in = tag_i;
    end else begin : g_rest
      assign rem_in = rem_q[s-1];
      assign nq_in  = nq_q[s-1];
      assign dm_in  = dm_q[s-1];
      assign neg_in = neg_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    assign trial = {rem_in, nq_in[63]};
    assign ge    = trial >= {1'b0, dm_in};

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= ge ? 31'(trial - {1'b0, dm_in}) : trial[30:0];
        nq_q[s]  <= {nq_in[62:0], ge};
        dm_q[s]  <= dm_in;
        neg_q[s] <= neg_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quot_o  = nq_q[DIV_STAGES-1];
  assign neg_o   = neg_q[DIV_STAGES-1];
  assign tag_o   = tag_q[DIV_STAGES-1];
endmodule

[sv/bcomp_pback.sv]
// pressure back stages: quotient sign, correction terms, clamp and output register
// depends on bcomp_pkg
module bcomp_pback (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [63:0]          quot_i,
  input  logic                 neg_i,
  input  bcomp_pkg::tag_t      tag_i,
  input  bcomp_pkg::cal_t      cal_i,
  output logic                 valid_o,
  output bcomp_pkg::out_word_t word_o
);
  import bcomp_pkg::*;

  logic [7:0] vld_q;
  tag_t tag_q [7];
  logic [63:0] p_q [5];
  logic [63:0] sqll_q, sq_q, bt_q, bt2_q, bt3_q, at_q, s_q, r_q;
  logic [31:0] sqhl_q, hi8_q, hi9_q;
  logic signed [49:0] lo8_q, lo9_q, h8, h9;
  logic [63:0] ps, sq_hl2;
  out_word_t word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_comb begin
    ps     = 64'($signed(p_q[0]) >>> 13);
    h8     = $signed({1'b0, p_q[0][63:32]}) * cal_i.p8;
    h9     = $signed({1'b0, sq_q[63:32]}) * cal_i.p9;
    sq_hl2 = {sqhl_q[30:0], 1'b0, 32'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < 7; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
      p_q[0] <= neg_i ? 64'(-quot_i) : quot_i;
      for (int i = 1; i < 5; i++) begin
        p_q[i] <= p_q[i-1];
      end
      // wrapped square of the scaled quotient and the p8 partials
      sqll_q <= ps[31:0] * ps[31:0];
      sqhl_q <= ps[63:32] * ps[31:0];
      lo8_q  <= $signed({1'b0, p_q[0][31:0]}) * cal_i.p8;
      hi8_q  <= h8[31:0];
      sq_q   <= sqll_q + sq_hl2;
      bt_q   <= 64'($signed(join_pp(lo8_q, hi8_q)) >>> 19);
      lo9_q  <= $signed({1'b0, sq_q[31:0]}) * cal_i.p9;
      hi9_q  <= h9[31:0];
      bt2_q  <= bt_q;
      bt3_q  <= bt2_q;
      at_q   <= 64'($signed(join_pp(lo9_q, hi9_q)) >>> 25);
      s_q    <= p_q[4] + at_q + bt3_q;
      r_q    <= 64'($signed(s_q) >>> 8) + (64'(cal_i.p7) << 4);
      word_q.temperature_centi <= tag_q[6].temp;
      word_q.pressure_invalid  <= tag_q[6].inv;
      if (tag_q[6].inv || r_q[63]) begin
        word_q.pressure_q8 <= '0;
      end else if (|r_q[62:32]) begin
        word_q.pressure_q8 <= '1;
      end else begin
        word_q.pressure_q8 <= r_q[31:0];
      end
    end
  end

  assign valid_o = vld_q[7];
  assign word_o  = word_q;
endmodule

[sv/barometer_compensation_core.sv]
// barometer compensation core: calibration registers, raw masking and the full pipeline
// one word per cycle while the output is not stalled
// the 64-stage divider sets the depth; a stalled output holds the whole pipeline
// reset clears calibration registers to zero and empties the pipeline
// depends on bcomp_pkg, bcomp_temp, bcomp_pfront, bcomp_div, bcomp_pback
module barometer_compensation_core #(
  parameter int unsigned RAW_WIDTH = bcomp_pkg::RAW_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bcomp_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bcomp_pkg::out_word_t out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import bcomp_pkg::*;

  localparam logic [RAW_BITS-1:0] RawMask = ~RAW_BITS'((1 << (RAW_BITS - RAW_WIDTH)) - 1);

  logic [31:0] cal_q [6];
  cal_t cal;
  logic adv;
  logic [RAW_BITS-1:0] adc_t, adc_p, adc_p_t;
  logic v_t, v_f, v_d;
  logic signed [25:0] a_t;
  logic signed [23:0] temp_t;
  logic [63:0] nmag, quot;
  logic [30:0] dmag;
  logic neg_f, neg_d;
  tag_t tag_f, tag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        cal_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      case (cal_idx_e'(cfg_index_i))
        CAL_T1_T2: cal_q[0] <= cfg_data_i;
        CAL_T3_P1: cal_q[1] <= cfg_data_i;
        CAL_P2_P3: cal_q[2] <= cfg_data_i;
        CAL_P4_P5: cal_q[3] <= cfg_data_i;
        CAL_P6_P7: cal_q[4] <= cfg_data_i;
        CAL_P8_P9: cal_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = cal_q[0][15:0];
    cal.t2 = $signed(cal_q[0][31:16]);
    cal.t3 = $signed(cal_q[1][15:0]);
    cal.p1 = cal_q[1][31:16];
    cal.p2 = $signed(cal_q[2][15:0]);
    cal.p3 = $signed(cal_q[2][31:16]);
    cal.p4 = $signed(cal_q[3][15:0]);
    cal.p5 = $signed(cal_q[3][31:16]);
    cal.p6 = $signed(cal_q[4][15:0]);
    cal.p7 = $signed(cal_q[4][31:16]);
    cal.p8 = $signed(cal_q[5][15:0]);
    cal.p9 = $signed(cal_q[5][31:16]);
  end

  assign cfg_ready_o = 1'b1;
  assign adv         = ~(out_valid_o & out_stall_i);
  assign in_stall_o  = ~adv;
  assign adc_t       = in_word_i.raw_temperature & RawMask;
  assign adc_p       = in_word_i.raw_pressure & RawMask;

  bcomp_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .adc_t_i (adc_t),
    .adc_p_i (adc_p),
    .cal_i   (cal),
    .valid_o (v_t),
    .a_o     (a_t),
    .temp_o  (temp_t),
    .adc_p_o (adc_p_t)
  );

  bcomp_pfront u_pfront (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v_t),
    .a_i     (a_t),
    .temp_i  (temp_t),
    .adc_p_i (adc_p_t),
    .cal_i   (cal),
    .valid_o (v_f),
    .nmag_o  (nmag),
    .dmag_o  (dmag),
    .neg_o   (neg_f),
    .tag_o   (tag_f)
  );

  bcomp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v_f),
    .nmag_i  (nmag),
    .dmag_i  (dmag),
    .neg_i   (neg_f),
    .tag_i   (tag_f),
    .valid_o (v_d),
    .quot_o  (quot),
    .neg_o   (neg_d),
    .tag_o   (tag_d)
  );

  bcomp_pback u_pback (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v_d),
    .quot_i  (quot),
    .neg_i   (neg_d),
    .tag_i   (tag_d),
    .cal_i   (cal),
    .valid_o (out_valid_o),
    .word_o  (out_word_o)
  );
endmodule
